FILE: sv/avcm_pkg.sv
`timescale 1ns / 1ps

package avcm_pkg;

  localparam int MaxSamplesDef = 16;
  localparam int SampleBitsDef = 10;

  localparam int MagW = 22;
  localparam logic [MagW-1:0] MagMax = 22'h3FFFFF;

  // configuration register file
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPR    = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_BOTTOM = 3'd2,
    CFG_SENS   = 3'd3,
    CFG_REF    = 3'd4
  } cfg_idx_e;

  localparam logic [4:0]  SprRst    = 5'd10;
  localparam logic [15:0] TopRst    = 16'd2200;
  localparam logic [15:0] BottomRst = 16'd330;
  localparam logic [9:0]  SensRst   = 10'd83;
  localparam logic [12:0] RefRst    = 13'd5000;

  typedef struct packed {
    logic [4:0]  spr;
    logic [15:0] top;
    logic [15:0] bottom;
    logic [9:0]  sens;
    logic [12:0] ref_mv;
  } cfg_t;

  // microcode
  localparam int PcW = 5;
  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_AVG_DIV,
    OP_DIV_STEP,
    OP_SAVE_AVG,
    OP_LOAD_MUL,
    OP_MUL_STEP,
    OP_SAVE_DEN,
    OP_LOAD_DIV,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    XS_BOTTOM,
    XS_SENS,
    XS_AVG,
    XS_DIFF,
    XS_PROD
  } x_src_e;

  typedef enum logic [2:0] {
    YS_KV,
    YS_FS,
    YS_REF,
    YS_RSUM,
    YS_SCALE
  } y_src_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_LOOP_Y,
    C_LOOP_LC,
    C_IF_CUR,
    C_JUMP,
    C_END
  } cond_e;

  typedef struct packed {
    op_e    op;
    x_src_e xs;
    y_src_e ys;
    cond_e  cond;
    pc_t    target;
  } ctrl_t;

  typedef struct packed {
    logic  run;
    ctrl_t cw;
  } seq_ctl_t;

  typedef struct packed {
    logic start;
    logic y_more;
    logic lc_nz;
    logic cur;
    logic emit_ok;
  } dp_stat_t;

  localparam pc_t PcDivTail = 5'd10;
  localparam pc_t PcCurrent = 5'd13;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    cw = '{op: OP_NOP, xs: XS_PROD, ys: YS_REF, cond: C_END, target: '0};
    case (pc)
      // average = sum / count
      5'd0:  cw = '{op: OP_LOAD_AVG_DIV, xs: XS_PROD, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd1:  cw = '{op: OP_DIV_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_LC, target: 5'd1};
      5'd2:  cw = '{op: OP_SAVE_AVG, xs: XS_PROD, ys: YS_REF, cond: C_IF_CUR, target: PcCurrent};
      // voltage: den = bottom * 10 * (FS-1); num = avg * ref * (top+bottom)
      5'd3:  cw = '{op: OP_LOAD_MUL, xs: XS_BOTTOM, ys: YS_KV, cond: C_NEXT, target: '0};
      5'd4:  cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd4};
      5'd5:  cw = '{op: OP_SAVE_DEN, xs: XS_PROD, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd6:  cw = '{op: OP_LOAD_MUL, xs: XS_AVG, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd7:  cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd7};
      5'd8:  cw = '{op: OP_LOAD_MUL, xs: XS_PROD, ys: YS_RSUM, cond: C_NEXT, target: '0};
      5'd9:  cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd9};
      // shared tail: num / den, clip, emit
      5'd10: cw = '{op: OP_LOAD_DIV, xs: XS_PROD, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd11: cw = '{op: OP_DIV_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_LC, target: 5'd11};
      5'd12: cw = '{op: OP_EMIT, xs: XS_PROD, ys: YS_REF, cond: C_END, target: '0};
      // current: den = sens * FS; num = |avg - Z| * ref * 100000
      5'd13: cw = '{op: OP_LOAD_MUL, xs: XS_SENS, ys: YS_FS, cond: C_NEXT, target: '0};
      5'd14: cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd14};
      5'd15: cw = '{op: OP_SAVE_DEN, xs: XS_PROD, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd16: cw = '{op: OP_LOAD_MUL, xs: XS_DIFF, ys: YS_REF, cond: C_NEXT, target: '0};
      5'd17: cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd17};
      5'd18: cw = '{op: OP_LOAD_MUL, xs: XS_PROD, ys: YS_SCALE, cond: C_NEXT, target: '0};
      5'd19: cw = '{op: OP_MUL_STEP, xs: XS_PROD, ys: YS_REF, cond: C_LOOP_Y, target: 5'd19};
      5'd20: cw = '{op: OP_NOP, xs: XS_PROD, ys: YS_REF, cond: C_JUMP, target: PcDivTail};
      default: cw = '{op: OP_NOP, xs: XS_PROD, ys: YS_REF, cond: C_END, target: '0};
    endcase
    return cw;
  endfunction

endpackage

FILE: sv/avcm_seq.sv
`timescale 1ns / 1ps

module avcm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avcm_pkg::dp_stat_t  stat_i,
  output avcm_pkg::seq_ctl_t  ctl_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e           state_q;
  avcm_pkg::pc_t    pc_q;
  avcm_pkg::ctrl_t  cw;
  logic             adv;

  assign cw  = avcm_pkg::ucode(pc_q);
  // emit waits while the output register still holds an untaken item
  assign adv = (cw.op != avcm_pkg::OP_EMIT) || stat_i.emit_ok;

  assign ctl_o.run = (state_q == S_RUN);
  assign ctl_o.cw  = cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (stat_i.start) begin
            state_q <= S_RUN;
            pc_q    <= '0;
          end
        end
        S_RUN: begin
          if (adv) begin
            case (cw.cond)
              avcm_pkg::C_NEXT:    pc_q <= pc_q + 1'b1;
              avcm_pkg::C_LOOP_Y:  pc_q <= stat_i.y_more ? cw.target : pc_q + 1'b1;
              avcm_pkg::C_LOOP_LC: pc_q <= stat_i.lc_nz ? cw.target : pc_q + 1'b1;
              avcm_pkg::C_IF_CUR:  pc_q <= stat_i.cur ? cw.target : pc_q + 1'b1;
              avcm_pkg::C_JUMP:    pc_q <= cw.target;
              avcm_pkg::C_END: begin
                state_q <= S_IDLE;
                pc_q    <= '0;
              end
              default: begin
                state_q <= S_IDLE;
                pc_q    <= '0;
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/avcm_dp.sv
`timescale 1ns / 1ps

module avcm_dp #(
  parameter int MAX_SAMPLES = avcm_pkg::MaxSamplesDef,
  parameter int SAMPLE_BITS = avcm_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  avcm_pkg::cfg_t                cfg_i,
  input  avcm_pkg::seq_ctl_t            ctl_i,
  output avcm_pkg::dp_stat_t            stat_o,
  input  logic                          in_valid_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          quantity_o,
  output logic                          negative_o,
  output logic [avcm_pkg::MagW-1:0]     magnitude_o,
  output logic                          saturated_o
);

  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int SumW  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  // widest product: avg * ref(13b) * (top+bottom)(17b)
  localparam int AccW  = SAMPLE_BITS + 30;
  localparam int YW    = (SAMPLE_BITS + 4 > 17) ? SAMPLE_BITS + 4 : 17;
  localparam int LcW   = $clog2(AccW);
  localparam int KvVal = 10 * ((1 << SAMPLE_BITS) - 1);
  localparam int FsVal = 1 << SAMPLE_BITS;
  localparam int Scale = 100000;

  localparam logic [SAMPLE_BITS-1:0] ZeroPt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SumW-1:0]        sum_q;
  logic [CntW-1:0]        cnt_q;
  logic                   cur_q;
  logic [AccW-1:0]        x_q, p_q, r_q, d_q;
  logic [YW-1:0]          y_q;
  logic [LcW-1:0]         lc_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic                   neg_q;
  logic                   nz_q;
  logic                   out_valid_q;

  logic [CntW-1:0]        n_eff;
  logic [CntW-1:0]        cnt_inc;
  logic [SumW-1:0]        sum_inc;
  logic                   accept;
  logic                   last;
  logic                   emit_ok;
  logic                   do_op;
  logic [SAMPLE_BITS-1:0] diff;
  logic [AccW-1:0]        x_sel;
  logic [YW-1:0]          y_sel;
  logic [AccW:0]          rem_sh;
  logic [AccW:0]          rem_sub;
  logic                   q_bit;
  logic [AccW-1:0]        mag_full;
  logic [avcm_pkg::MagW-1:0] mag;
  logic                   sat;

  // sample count: zero acts as one, too large acts as the maximum
  always_comb begin
    if (cfg_i.spr == '0) begin
      n_eff = CntW'(1);
    end else if (32'(cfg_i.spr) > 32'(MAX_SAMPLES)) begin
      n_eff = CntW'(MAX_SAMPLES);
    end else begin
      n_eff = CntW'(cfg_i.spr);
    end
  end

  assign cnt_inc = cnt_q + 1'b1;
  assign sum_inc = sum_q + SumW'(sample_i);
  assign accept  = in_valid_i && !ctl_i.run;
  assign last    = (cnt_inc >= n_eff);
  assign emit_ok = !out_valid_q || !out_stall_i;
  assign do_op   = ctl_i.run && ((ctl_i.cw.op != avcm_pkg::OP_EMIT) || emit_ok);

  assign diff = (avg_q >= ZeroPt) ? avg_q - ZeroPt : ZeroPt - avg_q;

  always_comb begin
    case (ctl_i.cw.xs)
      avcm_pkg::XS_BOTTOM: x_sel = AccW'(cfg_i.bottom);
      avcm_pkg::XS_SENS:   x_sel = AccW'(cfg_i.sens);
      avcm_pkg::XS_AVG:    x_sel = AccW'(avg_q);
      avcm_pkg::XS_DIFF:   x_sel = AccW'(diff);
      default:             x_sel = p_q;
    endcase
  end

  always_comb begin
    case (ctl_i.cw.ys)
      avcm_pkg::YS_KV:    y_sel = YW'(KvVal);
      avcm_pkg::YS_FS:    y_sel = YW'(FsVal);
      avcm_pkg::YS_RSUM:  y_sel = YW'({1'b0, cfg_i.top} + {1'b0, cfg_i.bottom});
      avcm_pkg::YS_SCALE: y_sel = YW'(Scale);
      default:            y_sel = YW'(cfg_i.ref_mv);
    endcase
  end

  // restoring divide, one quotient bit per step
  assign rem_sh  = {r_q, p_q[AccW-1]};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign q_bit   = (rem_sh >= {1'b0, d_q});

  // clip; zero divisor gives full scale unless the numerator is zero
  always_comb begin
    mag_full = p_q;
    if (d_q == '0) begin
      mag = nz_q ? avcm_pkg::MagMax : '0;
      sat = nz_q;
    end else if (mag_full > AccW'(avcm_pkg::MagMax)) begin
      mag = avcm_pkg::MagMax;
      sat = 1'b1;
    end else begin
      mag = mag_full[avcm_pkg::MagW-1:0];
      sat = 1'b0;
    end
  end

  assign stat_o.start   = accept && last;
  assign stat_o.y_more  = (y_q >> 1) != '0;
  assign stat_o.lc_nz   = (lc_q != '0);
  assign stat_o.cur     = cur_q;
  assign stat_o.emit_ok = emit_ok;

  assign out_valid_o = out_valid_q;

  // accept and emit never share a cycle: input is stalled while the program runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_op && (ctl_i.cw.op == avcm_pkg::OP_EMIT)) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
        cnt_q       <= '0;
        cur_q       <= !cur_q;
      end else begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_q <= 1'b0;
        end
        if (accept) begin
          sum_q <= sum_inc;
          cnt_q <= cnt_inc;
        end
      end
    end
  end

  // arithmetic registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_op) begin
      case (ctl_i.cw.op)
        avcm_pkg::OP_LOAD_AVG_DIV: begin
          p_q  <= AccW'(sum_q) << (AccW - SumW);
          d_q  <= AccW'(cnt_q);
          r_q  <= '0;
          lc_q <= LcW'(SumW - 1);
        end
        avcm_pkg::OP_DIV_STEP: begin
          p_q  <= {p_q[AccW-2:0], q_bit};
          r_q  <= q_bit ? rem_sub[AccW-1:0] : rem_sh[AccW-1:0];
          lc_q <= lc_q - 1'b1;
        end
        avcm_pkg::OP_SAVE_AVG: begin
          avg_q <= p_q[SAMPLE_BITS-1:0];
          neg_q <= cur_q && (p_q[SAMPLE_BITS-1:0] < ZeroPt) && (cfg_i.ref_mv != '0);
        end
        avcm_pkg::OP_LOAD_MUL: begin
          x_q <= x_sel;
          y_q <= y_sel;
          p_q <= '0;
        end
        avcm_pkg::OP_MUL_STEP: begin
          if (y_q[0]) begin
            p_q <= p_q + x_q;
          end
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
        avcm_pkg::OP_SAVE_DEN: begin
          d_q <= p_q;
        end
        avcm_pkg::OP_LOAD_DIV: begin
          r_q  <= '0;
          lc_q <= LcW'(AccW - 1);
          nz_q <= (p_q != '0);
        end
        avcm_pkg::OP_EMIT: begin
          quantity_o  <= cur_q;
          negative_o  <= neg_q;
          magnitude_o <= mag;
          saturated_o <= sat;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/averaged_voltage_current_meter.sv
`timescale 1ns / 1ps
// Every accepted sample is added to the running sum; the completing sample
// also starts a microcode run through the bit-serial multiplier and the
// one-bit-per-cycle divider, plus any wait on a full output; input stalls.
// Throughput: one sample per cycle between readings.
// Reset (async, active low): registers to defaults, sums cleared, voltage first.

module averaged_voltage_current_meter #(
  parameter int MAX_SAMPLES = avcm_pkg::MaxSamplesDef,
  parameter int SAMPLE_BITS = avcm_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  // reading output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              quantity_o,
  output logic                              negative_o,
  output logic [avcm_pkg::MagW-1:0]         magnitude_o,
  output logic                              saturated_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [avcm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [avcm_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  avcm_pkg::cfg_t     cfg_q;
  avcm_pkg::seq_ctl_t ctl;
  avcm_pkg::dp_stat_t stat;

  // Register file; write only while idle, unenforced; unknown indexes dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spr    <= avcm_pkg::SprRst;
      cfg_q.top    <= avcm_pkg::TopRst;
      cfg_q.bottom <= avcm_pkg::BottomRst;
      cfg_q.sens   <= avcm_pkg::SensRst;
      cfg_q.ref_mv <= avcm_pkg::RefRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        avcm_pkg::CFG_SPR:    cfg_q.spr    <= cfg_wdata_i[4:0];
        avcm_pkg::CFG_TOP:    cfg_q.top    <= cfg_wdata_i;
        avcm_pkg::CFG_BOTTOM: cfg_q.bottom <= cfg_wdata_i;
        avcm_pkg::CFG_SENS:   cfg_q.sens   <= cfg_wdata_i[9:0];
        avcm_pkg::CFG_REF:    cfg_q.ref_mv <= cfg_wdata_i[12:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer steps the microcode ROM; while it runs, input is stalled.
  // A finished reading sits in the output register and the next samples
  // keep flowing; only the emit step waits if that register is still full.
  assign in_stall_o = ctl.run;

  avcm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Datapath: sample accumulator, shift-add multiplier, restoring divider,
  // clip logic and the output register.
  avcm_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quantity_o  (quantity_o),
    .negative_o  (negative_o),
    .magnitude_o (magnitude_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: sv/avcm_checker.sv
`timescale 1ns / 1ps

module avcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          quantity_o,
  input logic                          negative_o,
  input logic [avcm_pkg::MagW-1:0]     magnitude_o,
  input logic                          saturated_o
);

  logic exp_qty_q;

  // readings alternate, voltage first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_qty_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_qty_q <= !exp_qty_q;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(magnitude_o))
    else $error("stalled reading changed");

  a_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quantity_o == exp_qty_q)
    else $error("reading kind out of order");

  a_vneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !quantity_o |-> !negative_o)
    else $error("negative voltage reading");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> magnitude_o == avcm_pkg::MagMax)
    else $error("saturated reading not at full scale");

endmodule

bind averaged_voltage_current_meter avcm_checker u_avcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .quantity_o  (quantity_o),
  .negative_o  (negative_o),
  .magnitude_o (magnitude_o),
  .saturated_o (saturated_o)
);
